@@ hdl/mqac_pkg.sv @@
// Shared types and constants of the multi-queue admission control block.
package mqac_pkg;

   localparam int NUM_CH    = 4;
   localparam int CH_W      = 2;
   localparam int DEPTH     = 16;
   localparam int PTR_W     = 4;
   localparam int CNT_W     = 5;
   localparam int SIZE_W    = 16;
   localparam int DESC_W    = 16;
   localparam int BYTES_W   = 20;
   localparam int SUMC_W    = 7;
   localparam int SUMB_W    = 22;
   localparam int RESC_W    = 8;
   localparam int STAT_W    = 16;
   localparam int ADDR_W    = CH_W + PTR_W;
   localparam int WORD_W    = SIZE_W + DESC_W;
   localparam int PADDR_W   = 5;
   localparam int PDATA_W   = 64;

   typedef enum logic [3:0] {
      OP_ENQ       = 4'd0,
      OP_REQ_FRONT = 4'd1,
      OP_REQ_BACK  = 4'd2,
      OP_DEQ       = 4'd3,
      OP_PEEK      = 4'd4,
      OP_RESERVE   = 4'd5,
      OP_REVERT    = 4'd6,
      OP_CLR_CH    = 4'd7,
      OP_CLR_ALL   = 4'd8,
      OP_STATS_CH  = 4'd9,
      OP_STATS_ALL = 4'd10
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FAIL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      REG_BYTE_LIMITS = 2'd0,
      REG_COUNT_LIMITS = 2'd1,
      REG_DROP_MASK = 2'd2
   } reg_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_EXEC = 2'd1,
      S_RESP = 2'd2
   } state_type;

   typedef struct packed {
      logic [63:0] byte_limits;
      logic [31:0] count_limits;
      logic [3:0]  drop_mask;
   } cfg_type;

endpackage

@@ hdl/mqac_ram.sv @@
// Slot memory holding descriptor and size of every queue entry.
module mqac_ram (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [mqac_pkg::ADDR_W-1:0]  wr_addr,
   input  logic [mqac_pkg::WORD_W-1:0]  wr_data,
   input  logic [mqac_pkg::ADDR_W-1:0]  rd_addr,
   output logic [mqac_pkg::WORD_W-1:0]  rd_data
);

   logic [mqac_pkg::WORD_W-1:0] mem [2**mqac_pkg::ADDR_W];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

@@ hdl/mqac_core.sv @@
// Sequencer and per-channel queue state of the admission control block.
module mqac_core (
   input  logic                          clock,
   input  logic                          reset,
   input  mqac_pkg::cfg_type             cfg,
   input  logic                          start,
   output logic                          busy,
   input  logic [3:0]                    req_operation,
   input  logic [mqac_pkg::CH_W-1:0]     req_channel,
   input  logic [mqac_pkg::DESC_W-1:0]   req_descriptor,
   input  logic [mqac_pkg::SIZE_W-1:0]   req_msg_bytes,
   output logic                          rsp_valid,
   output logic [1:0]                    rsp_status,
   output logic [15:0]                   rsp_out_descriptor,
   output logic [15:0]                   rsp_out_bytes,
   output logic [4:0]                    rsp_dropped_now,
   output logic [4:0]                    rsp_queue_count,
   output logic [19:0]                   rsp_queue_bytes,
   output logic [15:0]                   rsp_dropped_total,
   output logic [15:0]                   rsp_rejected_total,
   output logic [4:0]                    rsp_peak_count,
   output logic [19:0]                   rsp_peak_bytes,
   output logic [6:0]                    rsp_all_peak_count,
   output logic [21:0]                   rsp_all_peak_bytes
);

   localparam int NC = mqac_pkg::NUM_CH;

   mqac_pkg::state_type state_ff, state_in;
   logic [3:0]                       op_ff, op_in;
   logic [mqac_pkg::CH_W-1:0]        ch_ff, ch_in;
   logic [mqac_pkg::DESC_W-1:0]      desc_ff, desc_in;
   logic [mqac_pkg::SIZE_W-1:0]      mb_ff, mb_in;
   logic [4:0]                       dropped_ff, dropped_in;
   logic [1:0]                       status_ff, status_in;
   logic [15:0]                      od_ff, od_in, ob_ff, ob_in;

   logic [mqac_pkg::PTR_W-1:0]   head_ff [NC], head_in [NC];
   logic [mqac_pkg::CNT_W-1:0]   cnt_ff  [NC], cnt_in  [NC];
   logic [mqac_pkg::BYTES_W-1:0] byt_ff  [NC], byt_in  [NC];
   logic [mqac_pkg::BYTES_W-1:0] resb_ff [NC], resb_in [NC];
   logic [mqac_pkg::RESC_W-1:0]  resc_ff [NC], resc_in [NC];
   logic [mqac_pkg::STAT_W-1:0]  dropc_ff[NC], dropc_in[NC];
   logic [mqac_pkg::STAT_W-1:0]  rejc_ff [NC], rejc_in [NC];
   logic [mqac_pkg::CNT_W-1:0]   pkc_ff  [NC], pkc_in  [NC];
   logic [mqac_pkg::BYTES_W-1:0] pkb_ff  [NC], pkb_in  [NC];
   logic [mqac_pkg::SUMC_W-1:0]  spc_ff, spc_in;
   logic [mqac_pkg::SUMB_W-1:0]  spb_ff, spb_in;

   logic                          wr_en, do_put, accept;
   logic [mqac_pkg::ADDR_W-1:0]   wr_addr, rd_addr;
   logic [mqac_pkg::WORD_W-1:0]   rd_data;
   logic [mqac_pkg::SIZE_W-1:0]   rd_size;
   logic [mqac_pkg::DESC_W-1:0]   rd_desc;

   logic [mqac_pkg::CNT_W-1:0]    cnt;
   logic [mqac_pkg::BYTES_W-1:0]  byt, resb;
   logic [mqac_pkg::RESC_W-1:0]   resc;
   logic [15:0]                   lb;
   logic [7:0]                    lc;
   logic                          dm, fits, use_res, evict, lim_rej;
   logic [mqac_pkg::SUMB_W-1:0]   need_b;
   logic [9:0]                    need_c;
   logic [mqac_pkg::PTR_W-1:0]    put_ptr;
   logic [mqac_pkg::SUMC_W-1:0]   sum_c;
   logic [mqac_pkg::SUMB_W-1:0]   sum_b;

   mqac_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({mb_ff, desc_ff}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_size = rd_data[mqac_pkg::WORD_W-1:mqac_pkg::DESC_W];
   assign rd_desc = rd_data[mqac_pkg::DESC_W-1:0];
   assign busy    = (state_ff == mqac_pkg::S_EXEC);
   assign accept  = start && !busy;

   assign cnt  = cnt_ff[ch_ff];
   assign byt  = byt_ff[ch_ff];
   assign resb = resb_ff[ch_ff];
   assign resc = resc_ff[ch_ff];
   assign lb   = cfg.byte_limits[ch_ff*16 +: 16];
   assign lc   = cfg.count_limits[ch_ff*8 +: 8];
   assign dm   = cfg.drop_mask[ch_ff];

   assign need_b  = {2'b00, byt} + {2'b00, resb} + {6'd0, mb_ff};
   assign need_c  = {5'd0, cnt} + {2'b00, resc} + 10'd1;
   assign fits    = ((lb == '0) || (need_b <= {6'd0, lb}))
                 && ((lc == '0) || (need_c <= {2'b00, lc}));
   assign use_res = (resc != '0) && (resb >= {4'd0, mb_ff});
   assign evict   = (op_ff == mqac_pkg::OP_ENQ) && !use_res && dm && !fits && (cnt != '0);
   assign lim_rej = !use_res && !fits && !(dm && (cnt == '0));

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mqac_pkg::S_IDLE, mqac_pkg::S_RESP: begin
            state_in = accept ? mqac_pkg::S_EXEC : mqac_pkg::S_IDLE;
         end
         mqac_pkg::S_EXEC: begin
            state_in = evict ? mqac_pkg::S_EXEC : mqac_pkg::S_RESP;
         end
         default: state_in = mqac_pkg::S_IDLE;
      endcase
   end

   // Item capture and memory read address.
   always_comb begin
      op_in   = op_ff;
      ch_in   = ch_ff;
      desc_in = desc_ff;
      mb_in   = mb_ff;
      rd_addr = {ch_ff, head_ff[ch_ff] + 1'b1};
      if (accept) begin
         op_in   = req_operation;
         ch_in   = req_channel;
         desc_in = req_descriptor;
         mb_in   = req_msg_bytes;
         rd_addr = {req_channel, head_ff[req_channel]};
      end
   end

   // Execution of one item: evictions one per cycle, then the final update.
   always_comb begin
      head_in    = head_ff;
      cnt_in     = cnt_ff;
      byt_in     = byt_ff;
      resb_in    = resb_ff;
      resc_in    = resc_ff;
      dropc_in   = dropc_ff;
      rejc_in    = rejc_ff;
      dropped_in = dropped_ff;
      status_in  = status_ff;
      od_in      = od_ff;
      ob_in      = ob_ff;
      wr_en      = 1'b0;
      do_put     = 1'b0;
      put_ptr    = head_ff[ch_ff] + cnt[mqac_pkg::PTR_W-1:0];
      if (accept) begin
         dropped_in = '0;
         status_in  = mqac_pkg::ST_OK;
         od_in      = '0;
         ob_in      = '0;
      end
      if (state_ff == mqac_pkg::S_EXEC) begin
         if (evict) begin
            byt_in[ch_ff]  = byt - {4'd0, rd_size};
            head_in[ch_ff] = head_ff[ch_ff] + 1'b1;
            cnt_in[ch_ff]  = cnt - 1'b1;
            if (dropc_ff[ch_ff] != '1) begin
               dropc_in[ch_ff] = dropc_ff[ch_ff] + 1'b1;
            end
            dropped_in = dropped_ff + 1'b1;
         end else begin
            case (op_ff)
               mqac_pkg::OP_ENQ, mqac_pkg::OP_REQ_FRONT, mqac_pkg::OP_REQ_BACK: begin
                  if (((op_ff == mqac_pkg::OP_ENQ) && lim_rej)
                      || (cnt >= mqac_pkg::CNT_W'(mqac_pkg::DEPTH))) begin
                     if (rejc_ff[ch_ff] != '1) begin
                        rejc_in[ch_ff] = rejc_ff[ch_ff] + 1'b1;
                     end
                     status_in = mqac_pkg::ST_FAIL;
                  end else begin
                     if ((op_ff == mqac_pkg::OP_ENQ) && use_res) begin
                        resc_in[ch_ff] = resc - 1'b1;
                        resb_in[ch_ff] = resb - {4'd0, mb_ff};
                     end
                     if (op_ff == mqac_pkg::OP_REQ_FRONT) begin
                        put_ptr        = head_ff[ch_ff] - 1'b1;
                        head_in[ch_ff] = put_ptr;
                     end
                     wr_en         = 1'b1;
                     do_put        = 1'b1;
                     cnt_in[ch_ff] = cnt + 1'b1;
                     byt_in[ch_ff] = byt + {4'd0, mb_ff};
                  end
               end
               mqac_pkg::OP_DEQ, mqac_pkg::OP_PEEK: begin
                  if (cnt == '0) begin
                     status_in = mqac_pkg::ST_EMPTY;
                  end else begin
                     od_in = rd_desc;
                     ob_in = rd_size;
                     if (op_ff == mqac_pkg::OP_DEQ) begin
                        byt_in[ch_ff]  = byt - {4'd0, rd_size};
                        head_in[ch_ff] = head_ff[ch_ff] + 1'b1;
                        cnt_in[ch_ff]  = cnt - 1'b1;
                     end
                  end
               end
               mqac_pkg::OP_RESERVE: begin
                  if (!dm) begin
                     if (!fits || (resc == '1)
                         || (({1'b0, resb} + {5'd0, mb_ff}) > {1'b0, {mqac_pkg::BYTES_W{1'b1}}}))
                     begin
                        status_in = mqac_pkg::ST_FAIL;
                     end else begin
                        resc_in[ch_ff] = resc + 1'b1;
                        resb_in[ch_ff] = resb + {4'd0, mb_ff};
                     end
                  end
               end
               mqac_pkg::OP_REVERT: begin
                  if (resc != '0) begin
                     resc_in[ch_ff] = resc - 1'b1;
                  end
                  resb_in[ch_ff] = (resb >= {4'd0, mb_ff}) ? resb - {4'd0, mb_ff} : '0;
               end
               mqac_pkg::OP_CLR_CH, mqac_pkg::OP_CLR_ALL: begin
                  for (int i = 0; i < NC; i++) begin
                     if ((op_ff == mqac_pkg::OP_CLR_ALL) || (ch_ff == mqac_pkg::CH_W'(i))) begin
                        head_in[i] = '0;
                        cnt_in[i]  = '0;
                        byt_in[i]  = '0;
                        resb_in[i] = '0;
                        resc_in[i] = '0;
                     end
                  end
               end
               mqac_pkg::OP_STATS_CH, mqac_pkg::OP_STATS_ALL: begin
                  for (int i = 0; i < NC; i++) begin
                     if ((op_ff == mqac_pkg::OP_STATS_ALL) || (ch_ff == mqac_pkg::CH_W'(i)))
                     begin
                        dropc_in[i] = '0;
                        rejc_in[i]  = '0;
                     end
                  end
               end
               default: status_in = mqac_pkg::ST_FAIL;
            endcase
         end
      end
   end

   assign wr_addr = {ch_ff, put_ptr};

   // Peak tracking follows the updated counts of the final cycle; the stats operations clear the peaks.
   always_comb begin
      sum_c  = '0;
      sum_b  = '0;
      pkc_in = pkc_ff;
      pkb_in = pkb_ff;
      spc_in = spc_ff;
      spb_in = spb_ff;
      for (int i = 0; i < NC; i++) begin
         sum_c = sum_c + mqac_pkg::SUMC_W'(cnt_in[i]);
         sum_b = sum_b + mqac_pkg::SUMB_W'(byt_in[i]);
      end
      if (do_put) begin
         if (cnt_in[ch_ff] > pkc_ff[ch_ff]) pkc_in[ch_ff] = cnt_in[ch_ff];
         if (byt_in[ch_ff] > pkb_ff[ch_ff]) pkb_in[ch_ff] = byt_in[ch_ff];
         if (sum_c > spc_ff) spc_in = sum_c;
         if (sum_b > spb_ff) spb_in = sum_b;
      end else if ((state_ff == mqac_pkg::S_EXEC) && !evict) begin
         for (int i = 0; i < NC; i++) begin
            if ((op_ff == mqac_pkg::OP_STATS_ALL)
                || ((op_ff == mqac_pkg::OP_STATS_CH) && (ch_ff == mqac_pkg::CH_W'(i)))) begin
               pkc_in[i] = '0;
               pkb_in[i] = '0;
            end
         end
         if (op_ff == mqac_pkg::OP_STATS_ALL) begin
            spc_in = '0;
            spb_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mqac_pkg::S_IDLE;
         spc_ff   <= '0;
         spb_ff   <= '0;
         for (int i = 0; i < NC; i++) begin
            head_ff[i]  <= '0;
            cnt_ff[i]   <= '0;
            byt_ff[i]   <= '0;
            resb_ff[i]  <= '0;
            resc_ff[i]  <= '0;
            dropc_ff[i] <= '0;
            rejc_ff[i]  <= '0;
            pkc_ff[i]   <= '0;
            pkb_ff[i]   <= '0;
         end
      end else begin
         state_ff <= state_in;
         spc_ff   <= spc_in;
         spb_ff   <= spb_in;
         head_ff  <= head_in;
         cnt_ff   <= cnt_in;
         byt_ff   <= byt_in;
         resb_ff  <= resb_in;
         resc_ff  <= resc_in;
         dropc_ff <= dropc_in;
         rejc_ff  <= rejc_in;
         pkc_ff   <= pkc_in;
         pkb_ff   <= pkb_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      ch_ff      <= ch_in;
      desc_ff    <= desc_in;
      mb_ff      <= mb_in;
      dropped_ff <= dropped_in;
      status_ff  <= status_in;
      od_ff      <= od_in;
      ob_ff      <= ob_in;
   end

   // Outputs.
   always_comb begin
      rsp_valid          = (state_ff == mqac_pkg::S_RESP);
      rsp_status         = status_ff;
      rsp_out_descriptor = od_ff;
      rsp_out_bytes      = ob_ff;
      rsp_dropped_now    = dropped_ff;
      rsp_queue_count    = cnt_ff[ch_ff];
      rsp_queue_bytes    = byt_ff[ch_ff];
      rsp_dropped_total  = dropc_ff[ch_ff];
      rsp_rejected_total = rejc_ff[ch_ff];
      rsp_peak_count     = pkc_ff[ch_ff];
      rsp_peak_bytes     = pkb_ff[ch_ff];
      rsp_all_peak_count = spc_ff;
      rsp_all_peak_bytes = spb_ff;
   end

endmodule

@@ hdl/multi_queue_admission_control.sv @@
// Top level: configuration registers and the queue engine.
//
// Four descriptor FIFOs of sixteen entries share one slot memory. An item
// is accepted when start is high and busy is low; its result appears for
// exactly one cycle with rsp_valid high, and the receiver cannot hold it off.
// The head slot of the addressed channel is read from the synchronous slot
// memory in the cycle of acceptance, and the counters are updated in the
// next cycle. A drop-oldest enqueue stays busy for each evicted entry,
// since each eviction needs the next head read. The result cycle overlaps
// the acceptance of the next item. The limits and the drop-oldest mask are
// written over the APB-style port at byte addresses 0, 8 and 16; the user
// must write them only while the block is idle; the block does not enforce it.
// Reset empties all queues, clears all counters and peaks and the
// configuration; slot contents are not cleared and need no clearing pass.
module multi_queue_admission_control (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [mqac_pkg::PADDR_W-1:0]    paddr,
   input  logic [mqac_pkg::PDATA_W-1:0]    pwdata,
   output logic [mqac_pkg::PDATA_W-1:0]    prdata,
   output logic                            pready,
   input  logic                            start,
   output logic                            busy,
   input  logic [3:0]                      req_operation,
   input  logic [1:0]                      req_channel,
   input  logic [15:0]                     req_descriptor,
   input  logic [15:0]                     req_msg_bytes,
   output logic                            rsp_valid,
   output logic [1:0]                      rsp_status,
   output logic [15:0]                     rsp_out_descriptor,
   output logic [15:0]                     rsp_out_bytes,
   output logic [4:0]                      rsp_dropped_now,
   output logic [4:0]                      rsp_queue_count,
   output logic [19:0]                     rsp_queue_bytes,
   output logic [15:0]                     rsp_dropped_total,
   output logic [15:0]                     rsp_rejected_total,
   output logic [4:0]                      rsp_peak_count,
   output logic [19:0]                     rsp_peak_bytes,
   output logic [6:0]                      rsp_all_peak_count,
   output logic [21:0]                     rsp_all_peak_bytes
);

   mqac_pkg::cfg_type cfg_ff, cfg_in;
   logic              wr;
   logic [1:0]        reg_idx;

   assign pready  = 1'b1;
   assign wr      = psel && penable && pwrite && pready;
   assign reg_idx = paddr[4:3];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (reg_idx)
            mqac_pkg::REG_BYTE_LIMITS:  cfg_in.byte_limits  = pwdata;
            mqac_pkg::REG_COUNT_LIMITS: cfg_in.count_limits = pwdata[31:0];
            mqac_pkg::REG_DROP_MASK:    cfg_in.drop_mask    = pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         mqac_pkg::REG_BYTE_LIMITS:  prdata = cfg_ff.byte_limits;
         mqac_pkg::REG_COUNT_LIMITS: prdata = {32'd0, cfg_ff.count_limits};
         mqac_pkg::REG_DROP_MASK:    prdata = {60'd0, cfg_ff.drop_mask};
         default:                    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mqac_core u_core (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .start              (start),
      .busy               (busy),
      .req_operation      (req_operation),
      .req_channel        (req_channel),
      .req_descriptor     (req_descriptor),
      .req_msg_bytes      (req_msg_bytes),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_out_descriptor (rsp_out_descriptor),
      .rsp_out_bytes      (rsp_out_bytes),
      .rsp_dropped_now    (rsp_dropped_now),
      .rsp_queue_count    (rsp_queue_count),
      .rsp_queue_bytes    (rsp_queue_bytes),
      .rsp_dropped_total  (rsp_dropped_total),
      .rsp_rejected_total (rsp_rejected_total),
      .rsp_peak_count     (rsp_peak_count),
      .rsp_peak_bytes     (rsp_peak_bytes),
      .rsp_all_peak_count (rsp_all_peak_count),
      .rsp_all_peak_bytes (rsp_all_peak_bytes)
   );

endmodule

@@ hdl/mqac_checker.sv @@
// Port-level checks of the admission control block, bound to the top level.
module mqac_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic [1:0] rsp_status
);

   // An accepted item raises busy in the cycle after acceptance.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("accepted item did not raise busy");

   // The engine only goes idle by delivering a result.
   a_fall_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid) else $error("busy fell without a result");

   // Results never come in consecutive cycles.
   a_single_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe held two cycles");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3) else $error("illegal status code");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !busy && !rsp_valid) else $error("activity right after reset");

endmodule

bind multi_queue_admission_control mqac_checker u_mqac_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_valid  (rsp_valid),
   .rsp_status (rsp_status)
);

@@ dv/multi_queue_admission_control_tb.sv @@
// Self-checking testbench of the multi-queue admission control block.
module multi_queue_admission_control_tb;

   localparam int MAX_CYCLES = 400000;
   localparam int EXP_DEPTH  = 64;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [mqac_pkg::PADDR_W-1:0] paddr = '0;
   logic [mqac_pkg::PDATA_W-1:0] pwdata = '0;
   logic [mqac_pkg::PDATA_W-1:0] prdata;
   logic pready, start = 1'b0, busy;
   logic [3:0] req_operation = '0;
   logic [1:0] req_channel = '0;
   logic [15:0] req_descriptor = '0, req_msg_bytes = '0;
   logic rsp_valid;
   logic [1:0] rsp_status;
   logic [15:0] rsp_out_descriptor, rsp_out_bytes;
   logic [4:0] rsp_dropped_now, rsp_queue_count;
   logic [19:0] rsp_queue_bytes;
   logic [15:0] rsp_dropped_total, rsp_rejected_total;
   logic [4:0] rsp_peak_count;
   logic [19:0] rsp_peak_bytes;
   logic [6:0] rsp_all_peak_count;
   logic [21:0] rsp_all_peak_bytes;

   typedef struct packed {
      logic [1:0] status;
      logic [15:0] desc, nbytes;
      logic [4:0] dropped, count;
      logic [19:0] qbytes;
      logic [15:0] drop_tot, rej_tot;
      logic [4:0] pk_count;
      logic [19:0] pk_bytes;
      logic [6:0] all_count;
      logic [21:0] all_bytes;
   } outcome_type;

   // Predicted results in order of acceptance; the two counters run freely.
   outcome_type exp_fifo[EXP_DEPTH];
   int unsigned exp_wr = 0, exp_rd = 0;

   // Shadow of the block's queues, counters and configuration.
   logic [63:0] lim_bytes_reg;
   logic [31:0] lim_count_reg;
   logic [3:0] drop_mask_reg;
   logic [15:0] slot_desc[mqac_pkg::NUM_CH][mqac_pkg::DEPTH];
   logic [15:0] slot_size[mqac_pkg::NUM_CH][mqac_pkg::DEPTH];
   int unsigned head[mqac_pkg::NUM_CH], cnt[mqac_pkg::NUM_CH], held[mqac_pkg::NUM_CH];
   int unsigned rsv_b[mqac_pkg::NUM_CH], rsv_c[mqac_pkg::NUM_CH];
   int unsigned drops[mqac_pkg::NUM_CH], rejects[mqac_pkg::NUM_CH];
   int unsigned pk_c[mqac_pkg::NUM_CH], pk_b[mqac_pkg::NUM_CH];
   int unsigned sum_pk_c, sum_pk_b;

   int unsigned cycles = 0, mismatches = 0, checked = 0, sent = 0, drops_seen = 0;

   multi_queue_admission_control u_top (.*);

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > MAX_CYCLES) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic bit room_for(int unsigned c, int unsigned add);
      int unsigned lb, lc;
      lb = lim_bytes_reg[16*c +: 16];
      lc = lim_count_reg[8*c +: 8];
      if (lb != 0 && held[c] + rsv_b[c] + add > lb) return 1'b0;
      if (lc != 0 && cnt[c] + rsv_c[c] + 1 > lc) return 1'b0;
      return 1'b1;
   endfunction

   function automatic int unsigned bump16(int unsigned v);
      return (v < 16'hFFFF) ? v + 1 : v;
   endfunction

   function automatic void pop_oldest(int unsigned c);
      held[c] -= slot_size[c][head[c]];
      head[c] = (head[c] + 1) % mqac_pkg::DEPTH;
      cnt[c]--;
   endfunction

   function automatic void insert_entry(int unsigned c, logic [15:0] d, logic [15:0] s,
                                        bit at_front);
      int unsigned idx, tc, tb;
      if (at_front) begin
         head[c] = (head[c] + mqac_pkg::DEPTH - 1) % mqac_pkg::DEPTH;
         idx = head[c];
      end else idx = (head[c] + cnt[c]) % mqac_pkg::DEPTH;
      slot_desc[c][idx] = d;
      slot_size[c][idx] = s;
      cnt[c]++;
      held[c] += s;
      if (cnt[c] > pk_c[c]) pk_c[c] = cnt[c];
      if (held[c] > pk_b[c]) pk_b[c] = held[c];
      tc = 0;
      tb = 0;
      for (int i = 0; i < mqac_pkg::NUM_CH; i++) begin
         tc += cnt[i];
         tb += held[i];
      end
      if (tc > sum_pk_c) sum_pk_c = tc;
      if (tb > sum_pk_b) sum_pk_b = tb;
   endfunction

   function automatic void empty_queue(int unsigned c);
      head[c] = 0; cnt[c] = 0; held[c] = 0; rsv_b[c] = 0; rsv_c[c] = 0;
   endfunction

   function automatic void zero_stats(int unsigned c);
      drops[c] = 0; rejects[c] = 0; pk_c[c] = 0; pk_b[c] = 0;
   endfunction

   function automatic outcome_type admit_item(logic [3:0] op, int unsigned c,
                                              logic [15:0] d, logic [15:0] mb);
      outcome_type r;
      bit use_rsv, dm;
      r = '0;
      dm = drop_mask_reg[c];
      case (op)
         mqac_pkg::OP_ENQ: begin
            use_rsv = rsv_c[c] != 0 && rsv_b[c] >= mb;
            if (!use_rsv) begin
               if (!room_for(c, mb) && dm)
                  while (cnt[c] != 0 && !room_for(c, mb)) begin
                     pop_oldest(c);
                     drops[c] = bump16(drops[c]);
                     r.dropped++;
                  end
               if (!room_for(c, mb) && !(dm && cnt[c] == 0)) begin
                  rejects[c] = bump16(rejects[c]);
                  r.status = mqac_pkg::ST_FAIL;
               end
            end
            if (r.status == mqac_pkg::ST_OK) begin
               if (cnt[c] >= mqac_pkg::DEPTH) begin
                  rejects[c] = bump16(rejects[c]);
                  r.status = mqac_pkg::ST_FAIL;
               end else begin
                  if (use_rsv) begin
                     rsv_c[c]--;
                     rsv_b[c] -= mb;
                  end
                  insert_entry(c, d, mb, 1'b0);
               end
            end
         end
         mqac_pkg::OP_REQ_FRONT, mqac_pkg::OP_REQ_BACK:
            if (cnt[c] >= mqac_pkg::DEPTH) begin
               rejects[c] = bump16(rejects[c]);
               r.status = mqac_pkg::ST_FAIL;
            end else insert_entry(c, d, mb, op == mqac_pkg::OP_REQ_FRONT);
         mqac_pkg::OP_DEQ, mqac_pkg::OP_PEEK:
            if (cnt[c] == 0) r.status = mqac_pkg::ST_EMPTY;
            else begin
               r.desc = slot_desc[c][head[c]];
               r.nbytes = slot_size[c][head[c]];
               if (op == mqac_pkg::OP_DEQ) pop_oldest(c);
            end
         mqac_pkg::OP_RESERVE:
            if (!dm) begin
               if (!room_for(c, mb) || rsv_c[c] >= 255 || rsv_b[c] + mb > 20'hFFFFF)
                  r.status = mqac_pkg::ST_FAIL;
               else begin
                  rsv_c[c]++;
                  rsv_b[c] += mb;
               end
            end
         mqac_pkg::OP_REVERT: begin
            if (rsv_c[c] > 0) rsv_c[c]--;
            rsv_b[c] = (rsv_b[c] >= mb) ? rsv_b[c] - mb : 0;
         end
         mqac_pkg::OP_CLR_CH: empty_queue(c);
         mqac_pkg::OP_CLR_ALL: for (int i = 0; i < mqac_pkg::NUM_CH; i++) empty_queue(i);
         mqac_pkg::OP_STATS_CH: zero_stats(c);
         mqac_pkg::OP_STATS_ALL: begin
            for (int i = 0; i < mqac_pkg::NUM_CH; i++) zero_stats(i);
            sum_pk_c = 0;
            sum_pk_b = 0;
         end
         default: r.status = mqac_pkg::ST_FAIL;
      endcase
      r.count = 5'(cnt[c]);
      r.qbytes = 20'(held[c]);
      r.drop_tot = 16'(drops[c]);
      r.rej_tot = 16'(rejects[c]);
      r.pk_count = 5'(pk_c[c]);
      r.pk_bytes = 20'(pk_b[c]);
      r.all_count = 7'(sum_pk_c);
      r.all_bytes = 22'(sum_pk_b);
      return r;
   endfunction

   // Result checker: every strobed result is matched against the oldest prediction.
   always @(posedge clock) begin
      outcome_type got, want;
      if (!reset && rsp_valid) begin
         got = {rsp_status, rsp_out_descriptor, rsp_out_bytes, rsp_dropped_now,
                rsp_queue_count, rsp_queue_bytes, rsp_dropped_total, rsp_rejected_total,
                rsp_peak_count, rsp_peak_bytes, rsp_all_peak_count, rsp_all_peak_bytes};
         if (exp_wr == exp_rd) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result %p", got);
         end else begin
            want = exp_fifo[exp_rd % EXP_DEPTH];
            exp_rd++;
            checked++;
            drops_seen += (got.dropped != 0);
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch at cycle %0d\n  expected %p\n  actual   %p",
                           cycles, want, got);
            end
         end
      end
   end

   task automatic write_reg(mqac_pkg::reg_type idx, logic [63:0] value);
      @(posedge clock);
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
      paddr <= mqac_pkg::PADDR_W'(8 * idx); pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (idx)
         mqac_pkg::REG_BYTE_LIMITS: lim_bytes_reg = value;
         mqac_pkg::REG_COUNT_LIMITS: lim_count_reg = value[31:0];
         default: drop_mask_reg = value[3:0];
      endcase
   endtask

   // Drain outstanding results, then leave the block time to settle.
   task automatic wait_idle();
      start <= 1'b0;
      while (exp_wr != exp_rd) @(posedge clock);
      repeat (24) @(posedge clock);
   endtask

   task automatic configure(logic [63:0] bl, logic [31:0] cl, logic [3:0] dm);
      wait_idle();
      write_reg(mqac_pkg::REG_BYTE_LIMITS, bl);
      write_reg(mqac_pkg::REG_COUNT_LIMITS, cl);
      write_reg(mqac_pkg::REG_DROP_MASK, dm);
   endtask

   // Start stays high after acceptance until the next item or an idle wait lowers it;
   // busy is high in the cycle after acceptance, so no item is taken twice.
   task automatic send_item(logic [3:0] op, int unsigned c, int unsigned d,
                            int unsigned mb, bit gaps = 1'b1);
      int unsigned gap;
      gap = gaps ? $urandom_range(0, 3) : 0;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_operation <= op; req_channel <= 2'(c);
      req_descriptor <= 16'(d); req_msg_bytes <= 16'(mb);
      do @(posedge clock); while (busy);
      exp_fifo[exp_wr % EXP_DEPTH] = admit_item(op, c % mqac_pkg::NUM_CH, 16'(d), 16'(mb));
      exp_wr++;
      sent++;
   endtask

   task automatic test_directed();
      configure(64'h0, 32'h0, 4'h0);
      send_item(mqac_pkg::OP_DEQ, 0, 0, 0);
      send_item(mqac_pkg::OP_PEEK, 1, 0, 0);
      send_item(mqac_pkg::OP_ENQ, 0, 16'hFFFF, 16'hFFFF);
      send_item(mqac_pkg::OP_ENQ, 0, 16'h0000, 16'h0000);
      send_item(mqac_pkg::OP_REQ_FRONT, 0, 16'hA5A5, 16'h5A5A);
      send_item(mqac_pkg::OP_REQ_BACK, 0, 16'h5A5A, 16'hA5A5);
      send_item(mqac_pkg::OP_PEEK, 0, 0, 0);
      send_item(mqac_pkg::OP_DEQ, 0, 0, 0);
      send_item(mqac_pkg::OP_RESERVE, 2, 0, 100);
      send_item(mqac_pkg::OP_ENQ, 2, 7, 60);
      send_item(mqac_pkg::OP_REVERT, 2, 0, 16'hFFFF);
      send_item(mqac_pkg::OP_REVERT, 2, 0, 5);
      send_item(4'd11, 3, 1, 1);
      send_item(4'd15, 3, 1, 1);
      // Fill one queue past its physical depth.
      for (int i = 0; i < mqac_pkg::DEPTH + 2; i++)
         send_item(mqac_pkg::OP_REQ_BACK, 3, i, 1, 1'b0);
      send_item(mqac_pkg::OP_ENQ, 3, 1, 1);
      send_item(mqac_pkg::OP_STATS_CH, 3, 0, 0);
      send_item(mqac_pkg::OP_CLR_CH, 3, 0, 0);
      send_item(mqac_pkg::OP_CLR_ALL, 0, 0, 0);
      send_item(mqac_pkg::OP_STATS_ALL, 0, 0, 0);
      // Limits: a reject on channel 0, and reserve with and without drop-oldest mode.
      configure(64'h0000_0000_0000_0064, 32'h0000_0003, 4'h2);
      for (int i = 0; i < 4; i++) send_item(mqac_pkg::OP_ENQ, 0, i, 30);
      send_item(mqac_pkg::OP_RESERVE, 0, 0, 90);
      for (int i = 0; i < 4; i++) send_item(mqac_pkg::OP_ENQ, 1, i, 30);
      send_item(mqac_pkg::OP_ENQ, 1, 9, 16'hFFFF);
      send_item(mqac_pkg::OP_RESERVE, 1, 0, 5);
   endtask

   task automatic run_random(int unsigned n);
      logic [3:0] op;
      int unsigned mb;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5: op = mqac_pkg::OP_ENQ;
            6: op = mqac_pkg::OP_REQ_FRONT;
            7: op = mqac_pkg::OP_REQ_BACK;
            8, 9, 10: op = mqac_pkg::OP_DEQ;
            11: op = mqac_pkg::OP_PEEK;
            12, 13: op = mqac_pkg::OP_RESERVE;
            14: op = mqac_pkg::OP_REVERT;
            15: op = ($urandom_range(0, 3) == 0) ? mqac_pkg::OP_CLR_ALL : mqac_pkg::OP_CLR_CH;
            16: op = ($urandom_range(0, 3) == 0) ? mqac_pkg::OP_STATS_ALL
                                                 : mqac_pkg::OP_STATS_CH;
            17: op = 4'($urandom_range(11, 15));
            default: op = mqac_pkg::OP_ENQ;
         endcase
         mb = ($urandom_range(0, 9) == 0) ? ($urandom & 32'hFFFF) : $urandom_range(0, 40);
         send_item(op, $urandom_range(0, 3), $urandom & 32'hFFFF, mb,
                   $urandom_range(0, 4) != 0);
      end
   endtask

   task automatic test_random_settings();
      run_random(300);
      configure({16'd120, 16'd0, 16'd60, 16'd200}, {8'd0, 8'd5, 8'd2, 8'd8}, 4'h5);
      run_random(350);
      configure(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 4'hF);
      run_random(200);
      configure({16'd1, 16'd80, 16'd150, 16'd40}, {8'd1, 8'd0, 8'd16, 8'd4}, 4'hA);
      run_random(350);
      configure({$urandom, $urandom} & 64'h00FF_00FF_00FF_00FF, $urandom & 32'h0F0F_0F0F,
                4'($urandom));
      run_random(300);
   endtask

   initial begin
      for (int c = 0; c < mqac_pkg::NUM_CH; c++) begin
         empty_queue(c);
         zero_stats(c);
      end
      sum_pk_c = 0; sum_pk_b = 0;
      lim_bytes_reg = '0; lim_count_reg = '0; drop_mask_reg = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_settings();
      wait_idle();
      $display("Sent %0d items, checked %0d results, %0d with evictions, %0d mismatches",
               sent, checked, drops_seen, mismatches);
      if (mismatches == 0 && exp_wr == exp_rd)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end
endmodule

@@ filelist.f @@
hdl/mqac_pkg.sv
hdl/mqac_ram.sv
hdl/mqac_core.sv
hdl/multi_queue_admission_control.sv
hdl/mqac_checker.sv
dv/multi_queue_admission_control_tb.sv
